@@ src/tcpsq_pkg.sv @@
// Package: shared constants, codes and payload types for the two-class stack/queue.
`timescale 1ns / 1ps
package tcpsq_pkg;

  localparam int unsigned DEPTH     = 128;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned REPORT_W  = 8;
  localparam logic [7:0]  QUOTA_RESET = 8'd4;

  typedef enum logic [1:0] {
    CMD_PUSH_URGENT = 2'd0,
    CMD_PUSH_NORMAL = 2'd1,
    CMD_RESOLVE     = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_URGENT_ADDED = 3'd0,
    ST_NORMAL_ADDED = 3'd1,
    ST_QUOTA        = 3'd2,
    ST_STACK_FULL   = 3'd3,
    ST_FIFO_FULL    = 3'd4,
    ST_URGENT_RES   = 3'd5,
    ST_NORMAL_RES   = 3'd6,
    ST_NOTHING      = 3'd7
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_OUT  = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] resolved_payload;
    logic [7:0]  urgent_pending;
    logic [7:0]  normal_pending;
    logic [7:0]  urgent_used;
  } out_item_t;

  typedef struct packed {
    logic load;
  } ctl_cmd_t;

endpackage

@@ src/tcpsq_if.sv @@
// Interfaces: valid/ready channels for command and result transactions.
`timescale 1ns / 1ps
interface tcpsq_in_if
  import tcpsq_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcpsq_out_if
  import tcpsq_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/two_class_priority_stack_queue.sv @@
// Top level: two-class priority stack/queue with quota-limited urgent class.
//
// Usage:
//   in_i  carries command transactions {command, payload}: push urgent,
//         push normal, or resolve the next item. Payload is the stored tag.
//   out_o carries exactly one result transaction per command: status,
//         resolved tag (zero unless resolved), stack and FIFO occupancy and
//         the number of urgent pushes admitted since reset.
//   cfg_we_i / cfg_wdata_i write the urgent quota; write only while idle.
// Latency and throughput:
//   A command is taken in the idle state; its result is valid the next
//   cycle, after the registered read port of the stack and FIFO memories.
//   The block takes no new command until the result has been delivered, set
//   by the controller: in_i.ready stays low until the result transaction completes.
// Reset:
//   Clears the stack count, admitted count and FIFO pointers, sets the quota
//   to 4. Stack and FIFO memories are not cleared: no entry is read before
//   being written.
// Stall:
//   While out_o.ready is low the result holds and no new command is taken.
`timescale 1ns / 1ps
module two_class_priority_stack_queue
  import tcpsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpsq_in_if.sink    in_i,
  tcpsq_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  ctl_cmd_t ctl_cmd;

  // Sequence accept / deliver.
  tcpsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (ctl_cmd)
  );

  // Hold state, memories and the result register.
  tcpsq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .item_i      (in_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (out_o.data)
  );

endmodule

@@ src/tcpsq_ctrl.sv @@
// Controller: accepts one command transaction, then holds the result until taken.
`timescale 1ns / 1ps
module tcpsq_ctrl
  import tcpsq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_OUT;
      end
      CS_OUT: begin
        if (out_ready_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.load  = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CS_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ src/tcpsq_datapath.sv @@
// Datapath: urgent stack, linear normal FIFO, counters and result registers.
`timescale 1ns / 1ps
module tcpsq_datapath
  import tcpsq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  input  in_item_t   item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output out_item_t  result_o
);

  logic [TAG_W-1:0] urg_mem [DEPTH];
  logic [TAG_W-1:0] nrm_mem [DEPTH];

  logic [CNT_W-1:0] urg_count_q, urg_count_d;
  logic [7:0]       urg_admitted_q, urg_admitted_d;
  logic [CNT_W-1:0] nrm_head_q, nrm_head_d;
  logic [CNT_W-1:0] nrm_tail_q, nrm_tail_d;
  logic [7:0]       quota_q;
  status_e          status_q, status_d;
  logic [TAG_W-1:0] urg_rd_q, nrm_rd_q;

  logic             urg_push, nrm_push, urg_pop, nrm_pop;
  logic [CNT_W-1:0] urg_top;
  logic [CNT_W-1:0] nrm_head_inc;
  logic [TAG_W-1:0] tag;
  logic [CNT_W-1:0] nrm_level;

  assign tag          = item_i.payload[TAG_W-1:0];
  assign urg_top      = urg_count_q - CNT_W'(1);
  assign nrm_head_inc = nrm_head_q + CNT_W'(1);

  // Decide the operation for the command on the input channel.
  always_comb begin
    urg_push = 1'b0;
    nrm_push = 1'b0;
    urg_pop  = 1'b0;
    nrm_pop  = 1'b0;
    status_d = ST_NOTHING;
    case (cmd_e'(item_i.command))
      CMD_PUSH_URGENT: begin
        if (urg_admitted_q >= quota_q) begin
          status_d = ST_QUOTA;
        end else if (urg_count_q >= CNT_W'(DEPTH)) begin
          status_d = ST_STACK_FULL;
        end else begin
          urg_push = 1'b1;
          status_d = ST_URGENT_ADDED;
        end
      end
      CMD_PUSH_NORMAL: begin
        if (nrm_tail_q >= CNT_W'(DEPTH)) begin
          status_d = ST_FIFO_FULL;
        end else begin
          nrm_push = 1'b1;
          status_d = ST_NORMAL_ADDED;
        end
      end
      CMD_RESOLVE: begin
        if (urg_count_q != '0) begin
          urg_pop  = 1'b1;
          status_d = ST_URGENT_RES;
        end else if (nrm_head_q < nrm_tail_q) begin
          nrm_pop  = 1'b1;
          status_d = ST_NORMAL_RES;
        end
      end
      default: status_d = ST_NOTHING;
    endcase
  end

  always_comb begin
    urg_count_d    = urg_count_q;
    urg_admitted_d = urg_admitted_q;
    nrm_head_d     = nrm_head_q;
    nrm_tail_d     = nrm_tail_q;
    if (urg_push) begin
      urg_count_d    = urg_count_q + CNT_W'(1);
      urg_admitted_d = urg_admitted_q + 8'd1;
    end
    if (urg_pop) urg_count_d = urg_top;
    if (nrm_push) nrm_tail_d = nrm_tail_q + CNT_W'(1);
    if (nrm_pop) begin
      // Drained: rewind both pointers.
      if (nrm_head_inc >= nrm_tail_q) begin
        nrm_head_d = '0;
        nrm_tail_d = '0;
      end else begin
        nrm_head_d = nrm_head_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      urg_count_q    <= '0;
      urg_admitted_q <= '0;
      nrm_head_q     <= '0;
      nrm_tail_q     <= '0;
      quota_q        <= QUOTA_RESET;
      status_q       <= ST_NOTHING;
    end else begin
      if (cfg_we_i) quota_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        urg_count_q    <= urg_count_d;
        urg_admitted_q <= urg_admitted_d;
        nrm_head_q     <= nrm_head_d;
        nrm_tail_q     <= nrm_tail_d;
        status_q       <= status_d;
      end
    end
  end

  // Urgent stack memory: one write or one registered read per transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && urg_push) urg_mem[urg_count_q[ADDR_W-1:0]] <= tag;
    if (cmd_i.load && urg_pop) urg_rd_q <= urg_mem[urg_top[ADDR_W-1:0]];
  end

  // Normal FIFO memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && nrm_push) nrm_mem[nrm_tail_q[ADDR_W-1:0]] <= tag;
    if (cmd_i.load && nrm_pop) nrm_rd_q <= nrm_mem[nrm_head_q[ADDR_W-1:0]];
  end

  assign nrm_level = nrm_tail_q - nrm_head_q;

  always_comb begin
    result_o.status           = status_q;
    result_o.resolved_payload = '0;
    case (status_q)
      ST_URGENT_RES: result_o.resolved_payload = 32'(urg_rd_q);
      ST_NORMAL_RES: result_o.resolved_payload = 32'(nrm_rd_q);
      default:       result_o.resolved_payload = '0;
    endcase
    result_o.urgent_pending = REPORT_W'(urg_count_q);
    result_o.normal_pending = REPORT_W'(nrm_level);
    result_o.urgent_used    = urg_admitted_q;
  end

endmodule
